// ===== src/assert_macros.svh =====
// Assertion macros shared by the fourier phase factor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define FPF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define FPF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fpf_pkg.sv =====
// Package with types and constants of the fourier phase factor block.
`default_nettype none

package fpf_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int NUM_CELLS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int STEP_W       = 5;

    localparam logic [29:0] TURN_SCALE  = 30'd683565276;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam int OUT_W = 24;
    localparam logic signed [24:0] OUT_LIMIT = 25'sd4194304;

    // atan(2^-i) in turns, scaled by 2^32.
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [31:0] wave_x;
        logic signed [31:0] wave_y;
        logic signed [31:0] wave_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] cos_out;
        logic signed [OUT_W-1:0] sin_out;
    } result_t;

    // Rotation state that travels down the cell chain.
    typedef struct packed {
        logic               flip;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cell_t;

endpackage

`default_nettype wire

// ===== src/fpf_cell.sv =====
// One CORDIC rotation cell of the chain.
`default_nettype none

module fpf_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic [fpf_pkg::STEP_W-1:0] step,
    input  wire logic                       prev_valid,
    input  wire fpf_pkg::cell_t             prev_data,
    output logic                            valid,
    output fpf_pkg::cell_t                  data
);
    import fpf_pkg::*;

    logic               valid_reg;
    cell_t              data_reg;
    cell_t              data_next;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] ang;

    always_comb
    begin
        xs  = prev_data.x >>> step;
        ys  = prev_data.y >>> step;
        ang = $signed(ATAN_TURNS[step]);
        data_next.flip = prev_data.flip;
        // Rotate toward zero residual angle.
        if (!prev_data.z[31])
        begin
            data_next.x = prev_data.x - ys;
            data_next.y = prev_data.y + xs;
            data_next.z = prev_data.z - ang;
        end
        else
        begin
            data_next.x = prev_data.x + ys;
            data_next.y = prev_data.y - xs;
            data_next.z = prev_data.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// ===== src/fpf_phase.sv =====
// Dot product, turn scaling and half-turn fold ahead of the CORDIC chain.
`default_nettype none

module fpf_phase (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            item_valid,
    input  wire fpf_pkg::item_t  item,
    output logic                 valid,
    output fpf_pkg::cell_t       data
);
    import fpf_pkg::*;

    logic [3:0]         valid_reg;
    logic signed [63:0] px_reg;
    logic signed [63:0] py_reg;
    logic signed [63:0] pz_reg;
    logic [63:0]        neg_reg;
    logic [63:0]        neg_next;
    logic [31:0]        hit_reg;
    logic [29:0]        lot_reg;
    logic [61:0]        hit_full;
    logic [61:0]        lot_full;
    logic [31:0]        ang;
    logic               flip;
    cell_t              data_reg;
    cell_t              data_next;

    always_comb
    begin
        // Products are Q20.44; dropping 12 bits leaves Q.32 radians.
        neg_next = 64'd0 - (64'(px_reg >>> 12) + 64'(py_reg >>> 12) + 64'(pz_reg >>> 12));
        hit_full = neg_reg[63:32] * TURN_SCALE;
        lot_full = neg_reg[31:0] * TURN_SCALE;
        ang      = hit_reg + {2'b00, lot_reg};
        // Angles in the second and third quarter turn are folded by a half turn.
        flip     = ang[31] ^ ang[30];
        data_next.flip = flip;
        data_next.x    = CORDIC_GAIN;
        data_next.y    = 32'sd0;
        data_next.z    = $signed({ang[31] ^ flip, ang[30:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= 64'(item.wave_x) * 64'(item.pos_x);
            py_reg   <= 64'(item.wave_y) * 64'(item.pos_y);
            pz_reg   <= 64'(item.wave_z) * 64'(item.pos_z);
            neg_reg  <= neg_next;
            hit_reg  <= hit_full[31:0];
            lot_reg  <= lot_full[61:32];
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg[3];
    assign data  = data_reg;

endmodule

`default_nettype wire

// ===== src/fourier_phase_factor.sv =====
// Top level of the fourier phase factor block: cos and sin of -(k.r).
// Register stages: 5 + NUM_CELLS (29 with 24 CORDIC steps): 4 front-end stages,
// one per cell, one output stage; result_valid rises once an accept has passed them all.
// Throughput: one transaction per cycle unless stalled; the cell chain is fully pipelined.
// A stalled output freezes the pipeline; a one-entry input skid keeps item_stall registered.
// Reset (rst_n low, asynchronous) clears all valid flags; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module fourier_phase_factor (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire fpf_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output fpf_pkg::result_t      result
);
    import fpf_pkg::*;

    // The whole pipeline advances together whenever the output register can move.
    logic    en;
    logic    item_accept;

    // Input skid entry catches a transaction that arrives while the pipeline is frozen.
    logic    skid_valid_reg;
    logic    skid_valid_next;
    item_t   skid_reg;
    logic    feed_valid;
    item_t   feed_item;

    logic    chain_valid [NUM_CELLS+1];
    cell_t   chain_data  [NUM_CELLS+1];

    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    // Rounds Q2.30 to Q2.22 toward minus infinity after adding half an LSB,
    // then clamps to plus or minus one.
    function automatic logic signed [OUT_W-1:0] round_clamp(input logic signed [31:0] v);
        logic signed [32:0] sum;
        logic signed [24:0] sh;
        logic signed [24:0] cl;
        sum = 33'(v) + 33'sd128;
        sh  = 25'(sum >>> 8);
        if (sh > OUT_LIMIT)
        begin
            cl = OUT_LIMIT;
        end
        else if (sh < -OUT_LIMIT)
        begin
            cl = -OUT_LIMIT;
        end
        else
        begin
            cl = sh;
        end
        return cl[OUT_W-1:0];
    endfunction

    assign en          = !result_valid_reg || !result_stall;
    assign item_stall  = skid_valid_reg;
    assign item_accept = item_valid && !skid_valid_reg;
    assign feed_valid  = skid_valid_reg || item_accept;
    assign feed_item   = skid_valid_reg ? skid_reg : item;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (item_accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && item_accept)
        begin
            skid_reg <= item;
        end
    end

    // Front end: exact products, radian sum, scaling into turns, and the fold.
    fpf_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (feed_valid),
        .item       (feed_item),
        .valid      (chain_valid[0]),
        .data       (chain_data[0])
    );

    // One rotation cell per CORDIC step, each using its own shift and angle.
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        fpf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .step       (STEP_W'(g)),
            .prev_valid (chain_valid[g]),
            .prev_data  (chain_data[g]),
            .valid      (chain_valid[g+1]),
            .data       (chain_data[g+1])
        );
    end

    // Output stage: rounding, clamping and undoing the half-turn fold.
    always_comb
    begin
        result_next.cos_out = round_clamp(chain_data[NUM_CELLS].x);
        result_next.sin_out = round_clamp(chain_data[NUM_CELLS].y);
        if (chain_data[NUM_CELLS].flip)
        begin
            result_next.cos_out = -result_next.cos_out;
            result_next.sin_out = -result_next.sin_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A transaction taken while the pipeline is frozen must land in the skid entry.
    `FPF_ASSERT_NEXT(a_skid_capture, item_accept && !en, skid_valid_reg,
        "accepted transaction lost while pipeline frozen")
    // The skid entry holds its transaction until the pipeline moves again.
    `FPF_ASSERT_NEXT(a_skid_hold, skid_valid_reg && !en, skid_valid_reg && $stable(skid_reg),
        "skid entry changed while pipeline frozen")
    // Results never leave the range of plus or minus one.
    `FPF_ASSERT_IMPL(a_out_range, result_valid_reg,
        (result_reg.cos_out <= OUT_LIMIT[OUT_W-1:0] || result_reg.cos_out[OUT_W-1])
        && (result_reg.sin_out <= OUT_LIMIT[OUT_W-1:0] || result_reg.sin_out[OUT_W-1])
        && result_reg.cos_out >= -$signed(OUT_LIMIT[OUT_W-1:0])
        && result_reg.sin_out >= -$signed(OUT_LIMIT[OUT_W-1:0]),
        "result outside unit range")

endmodule

`default_nettype wire

// ===== sim/tb_fourier_phase_factor.sv =====
// Self-checking testbench for the fourier phase factor block.
`default_nettype none

module tb_fourier_phase_factor;

    import fpf_pkg::item_t;
    import fpf_pkg::result_t;

    // Rotation count of the block, capped the same way the hardware caps it.
    localparam int ROT_STEPS = (fpf_pkg::CORDIC_STEPS > 32) ? 32 : fpf_pkg::CORDIC_STEPS;

    // Fixed-point constants of the phase computation, kept locally so that a
    // wrong value in the package shows up as a mismatch.
    localparam logic [63:0]        RAD_TO_TURN = 64'd683565276;
    localparam logic signed [63:0] ROT_GAIN    = 64'sd652032874;
    localparam logic signed [63:0] UNIT_LIMIT  = 64'sd4194304;

    localparam logic [31:0] ATAN_TURN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Field extremes and one radian per length unit in Q4.28.
    localparam logic signed [31:0] FIELD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FIELD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_RAD   = 32'sh1000_0000;

    // Positions in Q16.16 that give phases near the quarter turns when the
    // wave vector is one radian per length unit.
    localparam logic signed [31:0] POS_QUARTER = 32'sd102944;
    localparam logic signed [31:0] POS_HALF    = 32'sd205887;
    localparam logic signed [31:0] POS_3QUART  = 32'sd308831;
    localparam logic signed [31:0] POS_FULL    = 32'sd411775;

    // Watchdog: cycles in a row with no transaction on either channel.
    localparam int STUCK_LIMIT = 2000;
    // Settling time after the last result, a bit above the pipeline depth.
    localparam int SETTLE_CYCLES = 40;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Expected cos/sin pairs in the order their input transactions were accepted.
    result_t expected_factors [$];
    int      items_sent = 0;
    int      factors_checked = 0;
    int      mismatches = 0;

    // Idling switches for the two channels; the tests turn them on and off.
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    int      rx_stall_left = 0;

    result_t got_factor;
    result_t want_factor;

    fourier_phase_factor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Computes cos and sin of -(k.r) exactly as the hardware must: truncated
    // dot product, conversion to turns with natural wrap, a half-turn fold and
    // a gain-compensated rotation, then rounding to Q2.22 with a clamp.
    function automatic result_t phase_factor(item_t it);
        logic signed [63:0] prod;
        logic signed [63:0] dot;
        logic [63:0]        turns_q;
        logic [31:0]        ang;
        logic [31:0]        ang_shift;
        logic               flip;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] a;
        logic signed [63:0] c;
        logic signed [63:0] s;
        result_t            r;
        dot = '0;
        prod = 64'($signed(it.wave_x)) * 64'($signed(it.pos_x));
        dot = dot + (prod >>> 12);
        prod = 64'($signed(it.wave_y)) * 64'($signed(it.pos_y));
        dot = dot + (prod >>> 12);
        prod = 64'($signed(it.wave_z)) * 64'($signed(it.pos_z));
        dot = dot + (prod >>> 12);
        // Whole turns fall off the top of the 64-bit product.
        turns_q = (-dot) * RAD_TO_TURN;
        ang = turns_q[63:32];
        // Angles in the left half plane are rotated by a half turn and the
        // results are negated at the end.
        ang_shift = ang + 32'h4000_0000;
        flip = ang_shift[31];
        if (flip)
        begin
            ang = ang - 32'h8000_0000;
        end
        z = 64'($signed(ang));
        x = ROT_GAIN;
        y = '0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            a = {32'b0, ATAN_TURN_TAB[i]};
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end
        end
        c = (x + 64'sd128) >>> 8;
        s = (y + 64'sd128) >>> 8;
        if (c > UNIT_LIMIT) c = UNIT_LIMIT;
        if (c < -UNIT_LIMIT) c = -UNIT_LIMIT;
        if (s > UNIT_LIMIT) s = UNIT_LIMIT;
        if (s < -UNIT_LIMIT) s = -UNIT_LIMIT;
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        r.cos_out = c[23:0];
        r.sin_out = s[23:0];
        return r;
    endfunction

    function automatic item_t make_item(logic signed [31:0] wx, logic signed [31:0] wy,
                                        logic signed [31:0] wz, logic signed [31:0] px,
                                        logic signed [31:0] py, logic signed [31:0] pz);
        item_t it;
        it.wave_x = wx;
        it.wave_y = wy;
        it.wave_z = wz;
        it.pos_x  = px;
        it.pos_y  = py;
        it.pos_z  = pz;
        return it;
    endfunction

    // Random value whose magnitude is spread over all scales, so that small,
    // physically sized phases are common as well as huge ones.
    function automatic logic signed [31:0] scaled_rand(int min_shift);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(min_shift, 31);
    endfunction

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(12, 48);
    endfunction

    // Offers one transaction and holds it until the block takes it. The
    // expectation is queued at the accepting edge.
    task automatic send_item(item_t it);
        int gap;
        gap = tx_idle_on ? idle_length() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        expected_factors = {expected_factors, phase_factor(it)};
        items_sent++;
    endtask

    // Drops valid after the last transaction of a test.
    task automatic release_input();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Holds the sender back until every queued expectation has been matched.
    task automatic drain_factors();
        while (expected_factors.size() != 0)
            @(posedge clk);
    endtask

    // Zero vectors, zero positions and the extreme field values. Extreme
    // inputs give phases of many thousands of turns, so these also check
    // that whole turns are discarded without saturation.
    task automatic test_field_extremes();
        send_item(make_item(0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, FIELD_MAX, FIELD_MIN, $urandom));
        send_item(make_item(FIELD_MAX, FIELD_MIN, $urandom, 0, 0, 0));
        send_item(make_item(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
        send_item(make_item(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
        send_item(make_item(FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
        send_item(make_item(FIELD_MAX, 0, 0, FIELD_MIN, 0, 0));
        send_item(make_item(-1, -1, -1, -1, -1, -1));
        send_item(make_item(1, 1, 1, 1, 1, 1));
        send_item(make_item(ONE_RAD, 0, 0, 32'sd65536, 0, 0));
        release_input();
    endtask

    // Phases right at and around the quarter turns, where the half-turn fold
    // switches and the outputs reach the clamp.
    task automatic test_quarter_turns();
        send_item(make_item(ONE_RAD, 0, 0, POS_QUARTER, 0, 0));
        send_item(make_item(ONE_RAD, 0, 0, POS_QUARTER + 1, 0, 0));
        send_item(make_item(0, ONE_RAD, 0, 0, -POS_QUARTER, 0));
        send_item(make_item(0, 0, ONE_RAD, 0, 0, POS_HALF));
        send_item(make_item(0, 0, ONE_RAD, 0, 0, -POS_HALF));
        send_item(make_item(ONE_RAD, 0, 0, POS_3QUART, 0, 0));
        send_item(make_item(-ONE_RAD, 0, 0, POS_3QUART, 0, 0));
        send_item(make_item(ONE_RAD, 0, 0, POS_FULL, 0, 0));
        send_item(make_item(ONE_RAD, ONE_RAD, 0, POS_QUARTER, -POS_QUARTER, 0));
        send_item(make_item(ONE_RAD, 0, 0, 32'sd1, 0, 0));
        send_item(make_item(ONE_RAD, 0, 0, -32'sd1, 0, 0));
        release_input();
    endtask

    // Uniform 32-bit fields: every bit of every field toggles, phases wrap
    // through many turns.
    task automatic test_full_range(int count);
        repeat (count)
        begin
            send_item(make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        end
        release_input();
    endtask

    // Fields of random magnitude, so that phases are mostly within a few
    // turns and the rotation sees all its angle ranges.
    task automatic test_small_phases(int count);
        repeat (count)
        begin
            send_item(make_item(scaled_rand(4), scaled_rand(4), scaled_rand(4),
                                scaled_rand(8), scaled_rand(8), scaled_rand(8)));
        end
        release_input();
    endtask

    // Back-to-back traffic: first with no stalls at all, then the pipeline
    // filled against a stalling receiver, then a sparse sender.
    task automatic test_streaming(int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count / 3)
            send_item(make_item($urandom, $urandom, $urandom,
                                scaled_rand(0), scaled_rand(0), scaled_rand(0)));
        release_input();
        // Let the whole pipeline empty before the stalling phase.
        drain_factors();
        rx_idle_on = 1'b1;
        repeat (count / 3)
            send_item(make_item(scaled_rand(0), scaled_rand(0), scaled_rand(0),
                                $urandom, $urandom, $urandom));
        release_input();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        repeat (count - 2 * (count / 3))
            send_item(make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        release_input();
        rx_idle_on = 1'b1;
    endtask

    // Receiver: stall periods of random length while idling is enabled.
    always @(posedge clk)
    begin
        if (rx_stall_left == 0 && rx_idle_on)
            rx_stall_left = idle_length();
        if (rx_stall_left > 0)
        begin
            result_stall <= 1'b1;
            rx_stall_left = rx_stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got_factor = result;
            if (expected_factors.size() == 0)
            begin
                $display("%0t: result with nothing expected: cos_out=%0d sin_out=%0d",
                         $time, $signed(got_factor.cos_out), $signed(got_factor.sin_out));
                mismatches++;
            end
            else
            begin
                want_factor = expected_factors.pop_front();
                if (got_factor.cos_out !== want_factor.cos_out)
                begin
                    $display("%0t: cos_out mismatch: expected %0d, actual %0d", $time,
                             $signed(want_factor.cos_out), $signed(got_factor.cos_out));
                    mismatches++;
                end
                if (got_factor.sin_out !== want_factor.sin_out)
                begin
                    $display("%0t: sin_out mismatch: expected %0d, actual %0d", $time,
                             $signed(want_factor.sin_out), $signed(got_factor.sin_out));
                    mismatches++;
                end
                factors_checked++;
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a transaction
    // for too long.
    initial
    begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STUCK_LIMIT, expected_factors.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_quarter_turns();
        test_full_range(650);
        // The sender waits here until every result has come back.
        drain_factors();
        test_small_phases(550);
        test_streaming(480);

        drain_factors();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transactions and checked %0d results: field extremes, quarter-turn",
                 items_sent, factors_checked);
        $display("phases, full-range and small random fields, streaming with and without stalls.");
        if (mismatches == 0 && expected_factors.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_factors.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
